>>> hw/rtl/transform_matrix_engine_defines.svh
// assertion helpers for the matrix engine
`ifndef TRANSFORM_MATRIX_ENGINE_DEFINES_SVH
`define TRANSFORM_MATRIX_ENGINE_DEFINES_SVH

// check that a condition implies a consequence on the same edge
`define TME_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// check that a condition implies a consequence on the next edge
`define TME_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/tme_pkg.sv
package tme_pkg;

    localparam int unsigned N = 4;

    typedef logic signed [31:0] t_word;
    typedef t_word t_row [N];

    typedef enum logic [3:0] {
        OP_LOAD_CUR = 4'd0,
        OP_LOAD_OPD = 4'd1,
        OP_MUL      = 4'd2,
        OP_ADD      = 4'd3,
        OP_SUB      = 4'd4,
        OP_TRANS    = 4'd5,
        OP_SCALE    = 4'd6,
        OP_READ     = 4'd7,
        OP_IDENT    = 4'd8
    } t_opcode;

    // what the lanes are asked to do for one row
    typedef enum logic [1:0] {
        LM_MUL,
        LM_ADD,
        LM_SUB,
        LM_PASS
    } t_lane_mode;

    function automatic t_word sat32(input logic signed [35:0] x);
        if (x > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

>>> hw/rtl/transform_matrix_engine.sv
// 4x4 signed fixed-point matrix engine (Q16.16 by default).
// input channel: i_valid/o_ready with i_opcode, i_row_index, i_elem0..3.
// output channel: o_valid/i_ready with o_out_row, o_col0..3, o_last_row.
// loads of a current or operand row emit nothing.
// mul, add, sub, translate, scale, read and identity each emit the four
// rows of the updated current matrix, row 0 first, last_row on row 3.
// four column lanes produce one row per pass: a row enters the lanes,
// products are registered, the merge sums and saturates and writes the
// row into a result register bank and the output register.
// each row passes through issue into the lanes, merge, and the output
// register; after the last row is taken, a commit step writes the
// results back and the engine returns to idle.
// new rows are written back only after all four are computed, so each
// row uses the old current matrix.
// reset clears both matrices and leaves the block idle and ready.
// when the receiver stalls, the engine holds the row in the output
// register and waits; no request is accepted until the op is done.
// unused opcodes are accepted and ignored.
`include "transform_matrix_engine_defines.svh"
module transform_matrix_engine #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_opcode,
    input  logic [1:0]         i_row_index,
    input  logic signed [31:0] i_elem0,
    input  logic signed [31:0] i_elem1,
    input  logic signed [31:0] i_elem2,
    input  logic signed [31:0] i_elem3,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_out_row,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);
    localparam int unsigned N = tme_pkg::N;
    localparam tme_pkg::t_word ONE = 32'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_MERGE,
        S_EMIT,
        S_COMMIT
    } t_state;

    t_state              r_state;
    tme_pkg::t_word      r_cur [N][N];
    tme_pkg::t_word      r_opd [N][N];
    tme_pkg::t_word      r_res [N][N];
    tme_pkg::t_word      r_rhs [N][N];
    tme_pkg::t_lane_mode r_mode;
    logic [1:0]          r_row;
    logic                r_valid;
    logic [1:0]          r_out_row;
    tme_pkg::t_row       r_out;

    logic                accept;
    tme_pkg::t_opcode    op;
    tme_pkg::t_word      elem [N];
    logic signed [63:0]  lane_prod [N][N];
    tme_pkg::t_lane_mode lane_mode [N];
    tme_pkg::t_word      lane_elem [N];
    tme_pkg::t_row       merged;
    logic                lane_en;

    assign op      = tme_pkg::t_opcode'(i_opcode);
    assign elem[0] = i_elem0;
    assign elem[1] = i_elem1;
    assign elem[2] = i_elem2;
    assign elem[3] = i_elem3;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign lane_en = (r_state == S_ISSUE);

    genvar gc;
    generate
        for (gc = 0; gc < N; gc++) begin : g_lane
            tme_pkg::t_row col;
            always_comb begin
                for (int k = 0; k < N; k++) begin
                    col[k] = r_rhs[k][gc];
                end
            end
            tme_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk      (i_clk),
                .i_mode     (r_mode),
                .i_en       (lane_en),
                .i_cur_row  (r_cur[r_row]),
                .i_opd_col  (col),
                .i_cur_elem (r_cur[r_row][gc]),
                .i_opd_elem (r_opd[r_row][gc]),
                .o_prod     (lane_prod[gc]),
                .o_mode     (lane_mode[gc]),
                .o_elem     (lane_elem[gc])
            );
        end
    endgenerate

    tme_merge u_merge (
        .i_prod (lane_prod),
        .i_mode (lane_mode),
        .i_elem (lane_elem),
        .o_row  (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_row   <= '0;
            r_mode  <= tme_pkg::LM_PASS;
            for (int r = 0; r < N; r++) begin
                for (int c = 0; c < N; c++) begin
                    r_cur[r][c] <= '0;
                    r_opd[r][c] <= '0;
                end
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_row <= '0;
                        case (op)
                            tme_pkg::OP_LOAD_CUR: begin
                                for (int c = 0; c < N; c++) begin
                                    r_cur[i_row_index][c] <= elem[c];
                                end
                            end
                            tme_pkg::OP_LOAD_OPD: begin
                                for (int c = 0; c < N; c++) begin
                                    r_opd[i_row_index][c] <= elem[c];
                                end
                            end
                            tme_pkg::OP_MUL: begin
                                r_rhs   <= r_opd;
                                r_mode  <= tme_pkg::LM_MUL;
                                r_state <= S_ISSUE;
                            end
                            tme_pkg::OP_ADD: begin
                                r_mode  <= tme_pkg::LM_ADD;
                                r_state <= S_ISSUE;
                            end
                            tme_pkg::OP_SUB: begin
                                r_mode  <= tme_pkg::LM_SUB;
                                r_state <= S_ISSUE;
                            end
                            tme_pkg::OP_TRANS: begin
                                // identity with dx, dy, dz down column 3
                                for (int r = 0; r < N; r++) begin
                                    for (int c = 0; c < N; c++) begin
                                        if (c == N - 1 && r < N - 1) begin
                                            r_rhs[r][c] <= elem[r];
                                        end else begin
                                            r_rhs[r][c] <= (r == c) ? ONE : '0;
                                        end
                                    end
                                end
                                r_mode      <= tme_pkg::LM_MUL;
                                r_state     <= S_ISSUE;
                            end
                            tme_pkg::OP_SCALE: begin
                                // identity with sx, sy, sz on the diagonal
                                for (int r = 0; r < N; r++) begin
                                    for (int c = 0; c < N; c++) begin
                                        if (r == c && r < N - 1) begin
                                            r_rhs[r][c] <= elem[r];
                                        end else begin
                                            r_rhs[r][c] <= (r == c) ? ONE : '0;
                                        end
                                    end
                                end
                                r_mode      <= tme_pkg::LM_MUL;
                                r_state     <= S_ISSUE;
                            end
                            tme_pkg::OP_READ: begin
                                r_mode  <= tme_pkg::LM_PASS;
                                r_state <= S_ISSUE;
                            end
                            tme_pkg::OP_IDENT: begin
                                for (int r = 0; r < N; r++) begin
                                    for (int c = 0; c < N; c++) begin
                                        r_cur[r][c] <= (r == c) ? ONE : '0;
                                    end
                                end
                                r_mode  <= tme_pkg::LM_PASS;
                                r_state <= S_ISSUE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ISSUE: r_state <= S_MERGE;
                S_MERGE: begin
                    r_res[r_row] <= merged;
                    r_out        <= merged;
                    r_out_row    <= r_row;
                    r_valid      <= 1'b1;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        if (r_row == 2'(N - 1)) begin
                            r_state <= S_COMMIT;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_COMMIT: begin
                    r_cur   <= r_res;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_out_row  = r_out_row;
    assign o_col0     = r_out[0];
    assign o_col1     = r_out[1];
    assign o_col2     = r_out[2];
    assign o_col3     = r_out[3];
    assign o_last_row = (r_out_row == 2'(N - 1));

    `TME_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `TME_ASSERT_NEXT(a_commit_idle, i_clk, i_rst_n, r_state == S_COMMIT, o_ready && !o_valid)
    `TME_ASSERT_NEXT(a_last_commit, i_clk, i_rst_n, o_valid && i_ready && o_last_row, r_state == S_COMMIT)
endmodule

>>> hw/rtl/tme_lane.sv
// one column lane: products of a current row with an operand column,
// or elementwise add/sub/pass
module tme_lane #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  tme_pkg::t_lane_mode  i_mode,
    input  logic                 i_en,
    input  tme_pkg::t_row        i_cur_row,
    input  tme_pkg::t_row        i_opd_col,
    input  tme_pkg::t_word       i_cur_elem,
    input  tme_pkg::t_word       i_opd_elem,
    output logic signed [63:0]   o_prod [tme_pkg::N],
    output tme_pkg::t_lane_mode  o_mode,
    output tme_pkg::t_word       o_elem
);
    // stage 1: products and elementwise result registered
    logic signed [63:0]  r_prod [tme_pkg::N];
    tme_pkg::t_lane_mode r_mode;
    tme_pkg::t_word      r_elem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < tme_pkg::N; k++) begin
                r_prod[k] <= (64'(i_cur_row[k]) * 64'(i_opd_col[k])) >>> FRAC_BITS;
            end
            r_mode <= i_mode;
            case (i_mode)
                tme_pkg::LM_ADD:
                    r_elem <= tme_pkg::sat32(36'(i_cur_elem) + 36'(i_opd_elem));
                tme_pkg::LM_SUB:
                    r_elem <= tme_pkg::sat32(36'(i_cur_elem) - 36'(i_opd_elem));
                default:
                    r_elem <= i_cur_elem;
            endcase
        end
    end

    assign o_prod = r_prod;
    assign o_mode = r_mode;
    assign o_elem = r_elem;
endmodule

>>> hw/rtl/tme_merge.sv
// merging stage: sums the four truncated products of each lane with
// saturation, or takes the elementwise value
module tme_merge (
    input  logic signed [63:0]  i_prod [tme_pkg::N][tme_pkg::N],
    input  tme_pkg::t_lane_mode i_mode [tme_pkg::N],
    input  tme_pkg::t_word      i_elem [tme_pkg::N],
    output tme_pkg::t_row       o_row
);
    logic signed [65:0] sum [tme_pkg::N];

    always_comb begin
        for (int c = 0; c < tme_pkg::N; c++) begin
            sum[c] = 66'(i_prod[c][0]) + 66'(i_prod[c][1])
                   + 66'(i_prod[c][2]) + 66'(i_prod[c][3]);
            if (i_mode[c] == tme_pkg::LM_MUL) begin
                if (sum[c] > 66'sd2147483647) begin
                    o_row[c] = 32'sh7fffffff;
                end else if (sum[c] < -66'sd2147483648) begin
                    o_row[c] = 32'sh80000000;
                end else begin
                    o_row[c] = sum[c][31:0];
                end
            end else begin
                o_row[c] = i_elem[c];
            end
        end
    end
endmodule

>>> tb/tb.sv
module tb;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXW = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINW = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [3:0] i_opcode = '0;
    logic [1:0] i_row_index = '0;
    logic signed [31:0] i_elem0 = '0, i_elem1 = '0, i_elem2 = '0, i_elem3 = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_out_row;
    logic signed [31:0] o_col0, o_col1, o_col2, o_col3;
    logic o_last_row;

    transform_matrix_engine dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] col [4];
        logic               last;
    } t_row_out;

    typedef struct {
        logic [3:0]         op;
        logic [1:0]         row;
        logic signed [31:0] e [4];
        logic               typed;
        logic signed [31:0] want [4];
    } t_stim;

    logic signed [31:0] cur_m [16];
    logic signed [31:0] opd_m [16];
    t_row_out expected_rows [$];
    int errors = 0;
    bit stim_done = 0;
    int hold_off = 0;

    function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return MAXW;
        if (x < -64'sd2147483648) return MINW;
        return x[31:0];
    endfunction

    // current = current x rhs, truncating each product before the exact sum
    function automatic void mat_mul(logic signed [31:0] rhs [16]);
        logic signed [31:0] res [16];
        logic signed [63:0] p;
        logic signed [66:0] acc;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    p = 64'(cur_m[r*4+k]) * 64'(rhs[k*4+c]);
                    acc += 67'(p >>> FRAC);
                end
                if (acc > 67'sd2147483647) res[r*4+c] = MAXW;
                else if (acc < -67'sd2147483648) res[r*4+c] = MINW;
                else res[r*4+c] = acc[31:0];
            end
        end
        cur_m = res;
    endfunction

    function automatic void predict_rows(logic [3:0] op, logic [1:0] ri,
                                         logic signed [31:0] e [4]);
        logic signed [31:0] t [16];
        t_row_out ro;
        for (int i = 0; i < 16; i++) t[i] = (i % 5 == 0) ? ONE : 32'sd0;
        case (op)
            tme_pkg::OP_LOAD_CUR: begin
                for (int i = 0; i < 4; i++) cur_m[ri*4+i] = e[i];
                return;
            end
            tme_pkg::OP_LOAD_OPD: begin
                for (int i = 0; i < 4; i++) opd_m[ri*4+i] = e[i];
                return;
            end
            tme_pkg::OP_MUL: mat_mul(opd_m);
            tme_pkg::OP_ADD: for (int i = 0; i < 16; i++)
                cur_m[i] = clamp32(64'(cur_m[i]) + 64'(opd_m[i]));
            tme_pkg::OP_SUB: for (int i = 0; i < 16; i++)
                cur_m[i] = clamp32(64'(cur_m[i]) - 64'(opd_m[i]));
            tme_pkg::OP_TRANS: begin t[3] = e[0]; t[7] = e[1]; t[11] = e[2]; mat_mul(t); end
            tme_pkg::OP_SCALE: begin t[0] = e[0]; t[5] = e[1]; t[10] = e[2]; mat_mul(t); end
            tme_pkg::OP_READ: ;
            tme_pkg::OP_IDENT: cur_m = t;
            default: return;
        endcase
        for (int r = 0; r < 4; r++) begin
            ro.row = r[1:0];
            for (int i = 0; i < 4; i++) ro.col[i] = cur_m[r*4+i];
            ro.last = (r == 3);
            expected_rows.push_back(ro);
        end
    endfunction

    // valid stays up across back-to-back requests; it drops only before a gap
    task automatic send(logic [3:0] op, logic [1:0] ri, logic signed [31:0] e [4]);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_row_index <= ri;
        i_elem0 <= e[0]; i_elem1 <= e[1]; i_elem2 <= e[2]; i_elem3 <= e[3];
        do @(posedge i_clk); while (!o_ready);
        predict_rows(op, ri, e);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return MAXW;
            2: return MINW;
            3: return ONE * $signed($urandom_range(0, 8) - 4);
            default: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
        endcase
    endfunction

    t_stim table_rows [$];

    function automatic t_stim mk(logic [3:0] op, logic [1:0] ri,
                                 logic signed [31:0] a, logic signed [31:0] b,
                                 logic signed [31:0] c, logic signed [31:0] d);
        t_stim s;
        s.op = op; s.row = ri;
        s.e[0] = a; s.e[1] = b; s.e[2] = c; s.e[3] = d;
        s.typed = 0;
        for (int i = 0; i < 4; i++) s.want[i] = '0;
        return s;
    endfunction

    initial begin
        t_stim s;
        logic signed [31:0] e [4];
        logic signed [31:0] diag;
        logic [3:0] op;
        int n;
        for (int i = 0; i < 16; i++) begin cur_m[i] = '0; opd_m[i] = '0; end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // readout after reset is all zero
        s = mk(tme_pkg::OP_READ, 2'd0, 0, 0, 0, 0); s.typed = 1; table_rows.push_back(s);
        table_rows.push_back(mk(tme_pkg::OP_IDENT, 2'd0, 0, 0, 0, 0));
        table_rows.push_back(mk(tme_pkg::OP_TRANS, 2'd0, ONE*3, -ONE*2, MAXW, 0));
        table_rows.push_back(mk(tme_pkg::OP_SCALE, 2'd0, MINW, ONE/2, -ONE, 0));
        for (int r = 0; r < 4; r++) begin
            table_rows.push_back(mk(tme_pkg::OP_LOAD_CUR, 2'(r), MAXW, MINW, -1,
                                    32'sh5555_aaaa));
            table_rows.push_back(mk(tme_pkg::OP_LOAD_OPD, 2'(r), MAXW, MAXW, MINW,
                                    -32'sh0000_8000));
        end
        table_rows.push_back(mk(tme_pkg::OP_ADD, 2'd0, 0, 0, 0, 0));
        table_rows.push_back(mk(tme_pkg::OP_SUB, 2'd0, 0, 0, 0, 0));
        table_rows.push_back(mk(tme_pkg::OP_MUL, 2'd0, 0, 0, 0, 0));
        table_rows.push_back(mk(4'd9, 2'd3, -1, -1, -1, -1));
        table_rows.push_back(mk(4'd15, 2'd2, MAXW, 0, MINW, 0));
        table_rows.push_back(mk(tme_pkg::OP_READ, 2'd0, 0, 0, 0, 0));
        s = mk(tme_pkg::OP_IDENT, 2'd0, 0, 0, 0, 0); s.typed = 1;
        s.want[0] = ONE; table_rows.push_back(s);

        foreach (table_rows[k]) begin
            s = table_rows[k];
            send(s.op, s.row, s.e);
            // typed rows: want[0] is the diagonal value, the rest is zero
            if (s.typed) begin
                for (int i = 0; i < 16; i++) begin
                    diag = (i % 5 == 0) ? s.want[0] : 32'sd0;
                    if (cur_m[i] !== diag) begin
                        $error("element %0d expected %0d actual %0d", i, diag, cur_m[i]);
                        errors++;
                    end
                end
            end
        end

        // long receiver stall while requests keep coming
        hold_off = 400;
        n = 0;
        while (n < 290) begin
            for (int i = 0; i < 4; i++) e[i] = rand_word();
            case ($urandom_range(0, 9))
                0, 1: op = tme_pkg::OP_LOAD_CUR;
                2, 3: op = tme_pkg::OP_LOAD_OPD;
                4: op = 4'($urandom_range(9, 15));
                default: op = 4'($urandom_range(2, 8));
            endcase
            if (op == tme_pkg::OP_READ && $urandom_range(0, 1)) op = tme_pkg::OP_IDENT;
            send(op, 2'($urandom_range(0, 3)), e);
            n++;
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        t_row_out w;
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (hold_off > 0) begin
                i_ready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (expected_rows.size() == 0) begin
                $error("unexpected row %0d", o_out_row);
                errors++;
            end else begin
                w = expected_rows.pop_front();
                if (o_out_row !== w.row) begin
                    $error("out_row expected %0d actual %0d", w.row, o_out_row); errors++;
                end
                if (o_col0 !== w.col[0]) begin
                    $error("col0 expected %0d actual %0d", w.col[0], o_col0); errors++;
                end
                if (o_col1 !== w.col[1]) begin
                    $error("col1 expected %0d actual %0d", w.col[1], o_col1); errors++;
                end
                if (o_col2 !== w.col[2]) begin
                    $error("col2 expected %0d actual %0d", w.col[2], o_col2); errors++;
                end
                if (o_col3 !== w.col[3]) begin
                    $error("col3 expected %0d actual %0d", w.col[3], o_col3); errors++;
                end
                if (o_last_row !== w.last) begin
                    $error("last_row expected %0d actual %0d", w.last, o_last_row); errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
